FILE: sv/rcdm_pkg.sv
// ----------------------------------------------------------------------------
// rcdm_pkg
// Types, constants and helpers shared by the drive mixer with failsafe.
// ----------------------------------------------------------------------------
package rcdm_pkg;

    localparam int SPEED_W  = 14;
    localparam int DB_W     = 7;
    localparam int MS_W     = 16;
    localparam int TIME_W   = 32;
    localparam int PCT_W    = 8;
    localparam int DRIVE_W  = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // |pct| * speed fits in 21 bits (128 * 16383)
    localparam int PROD_W   = 21;
    localparam int QUOT_W   = 15;
    localparam int MIX_W    = 16;
    localparam int PRE_W    = 17;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^21
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_100 = 22'd2684355;

    localparam logic [SPEED_W-1:0] RST_MAX_SPEED    = 14'd7200;
    localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 14'd4000;
    localparam logic [SPEED_W-1:0] RST_SPIN_SPEED   = 14'd3000;
    localparam logic [DB_W-1:0]    RST_DEADBAND     = 7'd5;
    localparam logic [MS_W-1:0]    RST_LOSS_TIMEOUT = 16'd1000;
    localparam logic [MS_W-1:0]    RST_STEP_MS      = 16'd3000;
    localparam logic [MS_W-1:0]    RST_PAUSE_MS     = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED    = 3'd0,
        CFG_CRUISE_SPEED = 3'd1,
        CFG_SPIN_SPEED   = 3'd2,
        CFG_DEADBAND     = 3'd3,
        CFG_LOSS_TIMEOUT = 3'd4,
        CFG_STEP_MS      = 3'd5,
        CFG_PAUSE_MS     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        STEP_FWD   = 3'd0,
        STEP_BACK  = 3'd1,
        STEP_SPINL = 3'd2,
        STEP_SPINR = 3'd3,
        STEP_PAUSE = 3'd4
    } t_step;

    typedef struct packed {
        logic [SPEED_W-1:0] max_speed;
        logic [SPEED_W-1:0] cruise_speed;
        logic [SPEED_W-1:0] spin_speed;
        logic [DB_W-1:0]    deadband;
        logic [MS_W-1:0]    loss_timeout;
        logic [MS_W-1:0]    step_ms;
        logic [MS_W-1:0]    pause_ms;
    } t_cfg;

    // command handed from the sequencer to the mixer pipeline
    typedef struct packed {
        logic                      emit;
        logic                      mix;
        logic signed [DRIVE_W-1:0] raw_left;
        logic signed [DRIVE_W-1:0] raw_right;
        logic                      rc_mode;
        t_step                     step;
        logic                      failsafe;
    } t_cmd;

    function automatic logic [PCT_W-1:0] f_mag(input logic signed [PCT_W-1:0] v);
        logic [PCT_W-1:0] r;
        r = v[PCT_W-1] ? PCT_W'(-v) : PCT_W'(v);
        return r;
    endfunction

endpackage

FILE: sv/rc_drive_mixer_with_failsafe.sv
// ----------------------------------------------------------------------------
// rc_drive_mixer_with_failsafe
// Differential-drive arcade mixer with RC takeover and link-loss failsafe.
// ----------------------------------------------------------------------------
// One control pass is taken per clock, unless a pass that produces a drive
// command is held back by a full mixer pipeline. A pass is held in the input
// register, where mode and demo-step state are updated; passes that produce a
// drive command then go through three more registers (speed products,
// reciprocal divide by 100/200, mix and clamp). Passes with no command leave
// after the input register.
module rc_drive_mixer_with_failsafe
    import rcdm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [31:0] now_ms, [39:32] throttle_pct, [47:40] steer_pct
    input  logic [47:0]          i_s_axis_tdata,
    // [0] link_ok
    input  logic [0:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [14:0] left_drive, [29:15] right_drive, [31:30] zero
    output logic [31:0]          o_m_axis_tdata,
    // [0] in_rc_mode, [3:1] demo_step, [4] failsafe_stop
    output logic [4:0]           o_m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    logic                     r_a_valid;
    logic [TIME_W-1:0]        r_a_now;
    logic                     r_a_link;
    logic signed [PCT_W-1:0]  r_a_thr, r_a_str;

    t_cmd cmd;
    logic mix_ready, a_go;

    logic signed [DRIVE_W-1:0] left, right;
    logic                      rc_mode, failsafe;
    t_step                     step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed    <= RST_MAX_SPEED;
            r_cfg.cruise_speed <= RST_CRUISE_SPEED;
            r_cfg.spin_speed   <= RST_SPIN_SPEED;
            r_cfg.deadband     <= RST_DEADBAND;
            r_cfg.loss_timeout <= RST_LOSS_TIMEOUT;
            r_cfg.step_ms      <= RST_STEP_MS;
            r_cfg.pause_ms     <= RST_PAUSE_MS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_SPEED:    r_cfg.max_speed    <= i_cfg_data[SPEED_W-1:0];
                CFG_CRUISE_SPEED: r_cfg.cruise_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_SPIN_SPEED:   r_cfg.spin_speed   <= i_cfg_data[SPEED_W-1:0];
                CFG_DEADBAND:     r_cfg.deadband     <= i_cfg_data[DB_W-1:0];
                CFG_LOSS_TIMEOUT: r_cfg.loss_timeout <= i_cfg_data[MS_W-1:0];
                CFG_STEP_MS:      r_cfg.step_ms      <= i_cfg_data[MS_W-1:0];
                CFG_PAUSE_MS:     r_cfg.pause_ms     <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    assign a_go            = r_a_valid && (mix_ready || !cmd.emit);
    assign o_s_axis_tready = !r_a_valid || a_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_a_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_a_now  <= i_s_axis_tdata[31:0];
            r_a_thr  <= i_s_axis_tdata[39:32];
            r_a_str  <= i_s_axis_tdata[47:40];
            r_a_link <= i_s_axis_tuser[0];
        end
    end

    rcdm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (a_go),
        .i_now   (r_a_now),
        .i_link  (r_a_link),
        .i_thr   (r_a_thr),
        .i_str   (r_a_str),
        .i_cfg   (r_cfg),
        .o_cmd   (cmd)
    );

    rcdm_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_a_valid && cmd.emit),
        .o_ready    (mix_ready),
        .i_cmd      (cmd),
        .i_thr      (r_a_thr),
        .i_str      (r_a_str),
        .i_cfg      (r_cfg),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_left     (left),
        .o_right    (right),
        .o_rc_mode  (rc_mode),
        .o_step     (step),
        .o_failsafe (failsafe)
    );

    assign o_m_axis_tdata = {2'b00, right, left};
    assign o_m_axis_tuser = {failsafe, step, rc_mode};

endmodule

FILE: sv/rcdm_seq.sv
// ----------------------------------------------------------------------------
// rcdm_seq
// Mode control: RC takeover, link-loss failsafe and auto demo step timing.
// ----------------------------------------------------------------------------
module rcdm_seq
    import rcdm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [TIME_W-1:0]        i_now,
    input  logic                     i_link,
    input  logic signed [PCT_W-1:0]  i_thr,
    input  logic signed [PCT_W-1:0]  i_str,
    input  t_cfg                     i_cfg,
    output t_cmd                     o_cmd
);

    logic              r_rc_mode, n_rc_mode;
    t_step             r_step, n_step, step_nxt;
    logic [TIME_W-1:0] r_step_start, n_step_start;
    logic [TIME_W-1:0] r_last_link, n_last_link;

    logic [PCT_W-1:0]  mag_t, mag_s;
    logic              take, rc_now;
    logic [TIME_W-1:0] d_link, d_step;
    logic [MS_W-1:0]   dur;
    logic              emit, mix, failsafe;

    logic signed [DRIVE_W-1:0] cruise, spin;

    assign mag_t  = f_mag(i_thr);
    assign mag_s  = f_mag(i_str);
    assign take   = !r_rc_mode && i_link &&
                    (mag_t > {1'b0, i_cfg.deadband} || mag_s > {1'b0, i_cfg.deadband});
    assign rc_now = r_rc_mode || take;
    assign d_link = i_now - r_last_link;
    assign d_step = i_now - r_step_start;
    assign dur    = (r_step == STEP_PAUSE) ? i_cfg.pause_ms : i_cfg.step_ms;

    always_comb begin
        unique case (r_step)
            STEP_FWD:   step_nxt = STEP_BACK;
            STEP_BACK:  step_nxt = STEP_SPINL;
            STEP_SPINL: step_nxt = STEP_SPINR;
            STEP_SPINR: step_nxt = STEP_PAUSE;
            STEP_PAUSE: step_nxt = STEP_FWD;
            default:    step_nxt = STEP_FWD;
        endcase
    end

    // next state
    always_comb begin
        n_rc_mode    = r_rc_mode;
        n_step       = r_step;
        n_step_start = r_step_start;
        n_last_link  = r_last_link;
        emit         = 1'b0;
        mix          = 1'b0;
        failsafe     = 1'b0;
        if (rc_now && i_link) begin
            n_rc_mode   = 1'b1;
            n_last_link = i_now;
            emit        = 1'b1;
            mix         = 1'b1;
        end else if (rc_now) begin
            if (d_link > {{(TIME_W-MS_W){1'b0}}, i_cfg.loss_timeout}) begin
                n_rc_mode    = 1'b0;
                n_step_start = i_now;
                emit         = 1'b1;
                failsafe     = 1'b1;
            end
        end else if (d_step >= {{(TIME_W-MS_W){1'b0}}, dur}) begin
            n_step       = step_nxt;
            n_step_start = i_now;
            emit         = 1'b1;
        end
    end

    assign cruise = $signed({1'b0, i_cfg.cruise_speed});
    assign spin   = $signed({1'b0, i_cfg.spin_speed});

    // outputs
    always_comb begin
        o_cmd.emit     = emit;
        o_cmd.mix      = mix;
        o_cmd.rc_mode  = n_rc_mode;
        o_cmd.step     = n_step;
        o_cmd.failsafe = failsafe;
        o_cmd.raw_left  = '0;
        o_cmd.raw_right = '0;
        if (!mix && !failsafe) begin
            unique case (n_step)
                STEP_FWD: begin
                    o_cmd.raw_left  = cruise;
                    o_cmd.raw_right = cruise;
                end
                STEP_BACK: begin
                    o_cmd.raw_left  = -cruise;
                    o_cmd.raw_right = -cruise;
                end
                STEP_SPINL: begin
                    o_cmd.raw_left  = -spin;
                    o_cmd.raw_right = spin;
                end
                STEP_SPINR: begin
                    o_cmd.raw_left  = spin;
                    o_cmd.raw_right = -spin;
                end
                default: begin
                    o_cmd.raw_left  = '0;
                    o_cmd.raw_right = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc_mode    <= 1'b0;
            r_step       <= STEP_FWD;
            r_step_start <= '0;
            r_last_link  <= '0;
        end else if (i_fire) begin
            r_rc_mode    <= n_rc_mode;
            r_step       <= n_step;
            r_step_start <= n_step_start;
            r_last_link  <= n_last_link;
        end
    end

`ifndef SYNTH
    a_rc_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rc_mode) |-> $past(i_fire) && $past(i_link))
        else $error("RC mode entered without a linked transaction");

    a_rc_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_rc_mode) |-> $past(i_fire) && !$past(i_link))
        else $error("RC mode left without link loss");

    a_step_hold_rc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rc_mode && $past(r_rc_mode) |-> $stable(r_step))
        else $error("demo step moved while in RC mode");

    a_fs_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_cmd.failsafe |=> !r_rc_mode && r_step_start == $past(i_now))
        else $error("failsafe did not restart auto timing");
`endif

endmodule

FILE: sv/rcdm_mix.sv
// ----------------------------------------------------------------------------
// rcdm_mix
// Deadband, arcade mix and clamp pipeline with output register.
// ----------------------------------------------------------------------------
module rcdm_mix
    import rcdm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_cmd                      i_cmd,
    input  logic signed [PCT_W-1:0]   i_thr,
    input  logic signed [PCT_W-1:0]   i_str,
    input  t_cfg                      i_cfg,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [DRIVE_W-1:0] o_left,
    output logic signed [DRIVE_W-1:0] o_right,
    output logic                      o_rc_mode,
    output t_step                     o_step,
    output logic                      o_failsafe
);

    logic rdy_o, rdy_c, rdy_b;

    // stage B: deadband and speed products
    logic              r_b_valid;
    t_cmd              r_b_cmd;
    logic [PROD_W-1:0] r_b_prod_t, r_b_prod_s;
    logic              r_b_neg_t, r_b_neg_s;

    // stage C: reciprocal divide
    logic                    r_c_valid;
    t_cmd                    r_c_cmd;
    logic signed [MIX_W-1:0] r_c_base, r_c_turn;

    logic              r_o_valid;

    logic [PCT_W-1:0]  mag_t, mag_s, eff_t, eff_s;
    logic [PROD_W:0]   prod_t, prod_s;
    logic [PROD_W+RECIP_W-1:0] rec_t, rec_s;
    logic [QUOT_W-1:0] q_t, q_s;
    logic [QUOT_W-1:0] half_s;
    logic signed [MIX_W-1:0] base, turn;
    logic signed [PRE_W-1:0] pre_l, pre_r, lim;
    logic signed [DRIVE_W-1:0] cl_l, cl_r;

    assign rdy_o   = !r_o_valid || i_ready;
    assign rdy_c   = !r_c_valid || rdy_o;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign o_ready = rdy_b;

    assign mag_t  = f_mag(i_thr);
    assign mag_s  = f_mag(i_str);
    assign eff_t  = (mag_t < {1'b0, i_cfg.deadband}) ? '0 : mag_t;
    assign eff_s  = (mag_s < {1'b0, i_cfg.deadband}) ? '0 : mag_s;
    assign prod_t = eff_t * i_cfg.max_speed;
    assign prod_s = eff_s * i_cfg.max_speed;

    always_ff @(posedge i_clk) begin
        if (rdy_b && i_valid) begin
            r_b_cmd    <= i_cmd;
            r_b_prod_t <= prod_t[PROD_W-1:0];
            r_b_prod_s <= prod_s[PROD_W-1:0];
            r_b_neg_t  <= i_thr[PCT_W-1];
            r_b_neg_s  <= i_str[PCT_W-1];
        end
    end

    assign rec_t  = r_b_prod_t * RECIP_100;
    assign rec_s  = r_b_prod_s * RECIP_100;
    assign q_t    = rec_t[RECIP_SHIFT +: QUOT_W];
    assign q_s    = rec_s[RECIP_SHIFT +: QUOT_W];
    assign half_s = {1'b0, q_s[QUOT_W-1:1]};
    assign base   = r_b_neg_t ? -$signed({1'b0, q_t}) : $signed({1'b0, q_t});
    assign turn   = r_b_neg_s ? -$signed({1'b0, half_s}) : $signed({1'b0, half_s});

    always_ff @(posedge i_clk) begin
        if (rdy_c && r_b_valid) begin
            r_c_cmd  <= r_b_cmd;
            r_c_base <= base;
            r_c_turn <= turn;
        end
    end

    assign lim = $signed({{(PRE_W-SPEED_W){1'b0}}, i_cfg.max_speed});

    always_comb begin
        if (r_c_cmd.mix) begin
            pre_l = PRE_W'(r_c_base) - PRE_W'(r_c_turn);
            pre_r = PRE_W'(r_c_base) + PRE_W'(r_c_turn);
        end else begin
            pre_l = PRE_W'($signed(r_c_cmd.raw_left));
            pre_r = PRE_W'($signed(r_c_cmd.raw_right));
        end
        if (pre_l > lim)       cl_l = lim[DRIVE_W-1:0];
        else if (pre_l < -lim) cl_l = DRIVE_W'(-lim);
        else                   cl_l = pre_l[DRIVE_W-1:0];
        if (pre_r > lim)       cl_r = lim[DRIVE_W-1:0];
        else if (pre_r < -lim) cl_r = DRIVE_W'(-lim);
        else                   cl_r = pre_r[DRIVE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o && r_c_valid) begin
            o_left     <= cl_l;
            o_right    <= cl_r;
            o_rc_mode  <= r_c_cmd.rc_mode;
            o_step     <= r_c_cmd.step;
            o_failsafe <= r_c_cmd.failsafe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (rdy_b) r_b_valid <= i_valid;
            if (rdy_c) r_c_valid <= r_b_valid;
            if (rdy_o) r_o_valid <= r_c_valid;
        end
    end

    assign o_valid = r_o_valid;

`ifndef SYNTH
    a_fs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && o_failsafe |-> o_left == '0 && o_right == '0 && !o_rc_mode)
        else $error("failsafe result is not a stop");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> PRE_W'(o_left) <= lim && PRE_W'(o_left) >= -lim &&
                      PRE_W'(o_right) <= lim && PRE_W'(o_right) >= -lim)
        else $error("drive command exceeds max speed");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> o_step == STEP_FWD || o_step == STEP_BACK || o_step == STEP_SPINL ||
                      o_step == STEP_SPINR || o_step == STEP_PAUSE)
        else $error("demo step out of range");

    a_mix_rc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_c_cmd.mix |-> r_c_cmd.rc_mode && !r_c_cmd.failsafe)
        else $error("mix command outside RC mode");
`endif

endmodule
